// ===== src/mjt_pkg.sv =====
// Package for the minimum-jerk trajectory unit: payload structs, codes,
// controller/datapath command and status types, a saturating add and a halving helper.
// No dependencies.
package mjt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_STEPS_DEF = 1024;
  localparam int TAU_BITS      = 30;
  localparam int IDX_W         = 11;
  localparam int STEPT_W       = 16;
  localparam int T_W           = IDX_W + STEPT_W;
  localparam int MB_W          = 48;
  localparam int TAU_W         = TAU_BITS + 1;

  localparam logic OP_PLAN = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic CFG_NUM_STEPS = 1'b0;
  localparam logic CFG_STEP_TIME = 1'b1;

  localparam logic [IDX_W-1:0]   NUM_STEPS_RST = 11'd125;
  localparam logic [STEPT_W-1:0] STEP_TIME_RST = 16'd1311;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic               op;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
  } mjt_in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [IDX_W-1:0]   sample_index;
    logic               last;
  } mjt_out_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_MUL, DP_DIV, DP_Q, DP_C3, DP_C4, DP_C5, DP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    M_T2, M_V0, M_V1, M_A, M_B, M_HORN
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_T2, ST_V0, ST_V1, ST_A, ST_B, ST_Q, ST_C3, ST_C4, ST_C5,
    ST_DIV, ST_HORN, ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic in_op;
    logic active;
    logic k_over;
    logic mul_done;
    logic div_done;
    logic hidx_zero;
    logic out_free;
  } status_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [63:0] half(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + {63'd0, x[63]};
    return y >>> 1;
  endfunction

endpackage

// ===== src/mjt_mul.sv =====
// Shared iterative multiplier: signed 64-bit operand times unsigned 48-bit
// operand, 16 bits per cycle, shifted right toward zero and saturated.
// Depends on mjt_pkg.
module mjt_mul #(
  parameter int FRAC_BITS = mjt_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic                      tau_shift,
  input  logic signed [63:0]        a,
  input  logic [mjt_pkg::MB_W-1:0]  b,
  output logic                      done,
  output logic signed [63:0]        res
);
  import mjt_pkg::*;

  logic               busy, fin, neg, shsel;
  logic [1:0]         cnt;
  logic [63:0]        amag;
  logic [MB_W-1:0]    bq;
  logic [111:0]       prod;
  logic [79:0]        pp;
  logic [111:0]       mag;
  logic               over;

  assign pp = amag * bq[MB_W-1 -: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= busy && (cnt == 2'd2);
      if (go && !busy && !fin) begin
        busy  <= 1'b1;
        cnt   <= 2'd0;
        neg   <= a[63];
        amag  <= a[63] ? 64'(-a) : 64'(a);
        bq    <= b;
        prod  <= '0;
        shsel <= tau_shift;
      end else if (busy) begin
        prod <= {prod[95:0], 16'd0} + {32'd0, pp};
        bq   <= {bq[MB_W-17:0], 16'd0};
        cnt  <= cnt + 2'd1;
        if (cnt == 2'd2) busy <= 1'b0;
      end
    end
  end

  always_comb begin
    mag  = shsel ? (prod >> TAU_BITS) : (prod >> FRAC_BITS);
    over = (|mag[111:64]) || (mag[63] && (!neg || (|mag[62:0])));
    if (over) res = neg ? S64_MIN : S64_MAX;
    else      res = neg ? 64'(-mag[63:0]) : 64'(mag[63:0]);
  end

  assign done = fin;

endmodule

// ===== src/mjt_div.sv =====
// Normalized-time divider: tau = floor(k * 2^30 / n) for k <= n,
// three restoring quotient bits per cycle. Depends on mjt_pkg.
module mjt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [mjt_pkg::IDX_W:0]     k,
  input  logic [mjt_pkg::IDX_W-1:0]   n,
  output logic                        done,
  output logic [mjt_pkg::TAU_W-1:0]   q
);
  import mjt_pkg::*;

  localparam int STEPS = TAU_BITS / 3;

  logic             busy, fin;
  logic [3:0]       cnt;
  logic [IDX_W-1:0] rem, rem_n;
  logic [2:0]       bits;
  logic [IDX_W:0]   r2;

  always_comb begin
    rem_n = rem;
    for (int j = 0; j < 3; j++) begin
      r2 = {rem_n, 1'b0};
      if (r2 >= {1'b0, n}) begin
        rem_n   = IDX_W'(r2 - {1'b0, n});
        bits[2-j] = 1'b1;
      end else begin
        rem_n   = r2[IDX_W-1:0];
        bits[2-j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= busy && (cnt == 4'(STEPS - 1));
      if (go && !busy && !fin) begin
        busy <= 1'b1;
        cnt  <= 4'd0;
        // integer part is 1 only when k == n
        if (k == {1'b0, n}) begin
          q   <= TAU_W'(1);
          rem <= '0;
        end else begin
          q   <= '0;
          rem <= k[IDX_W-1:0];
        end
      end else if (busy) begin
        q   <= {q[TAU_W-4:0], bits};
        rem <= rem_n;
        cnt <= cnt + 4'd1;
        if (cnt == 4'(STEPS - 1)) busy <= 1'b0;
      end
    end
  end

  assign done = fin;

endmodule

// ===== src/mjt_datapath.sv =====
// Datapath: config registers, plan coefficients, Horner accumulator,
// output register; hosts the shared multiplier and divider.
// Depends on mjt_pkg, mjt_mul, mjt_div.
module mjt_datapath #(
  parameter int FRAC_BITS = mjt_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS = mjt_pkg::MAX_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mjt_pkg::cmd_t                 cmd,
  output mjt_pkg::status_t              status,
  input  mjt_pkg::mjt_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mjt_pkg::mjt_out_t             out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mjt_pkg::STEPT_W-1:0]   cfg_data
);
  import mjt_pkg::*;

  logic [IDX_W-1:0]   num_steps, neff, sample_count;
  logic [STEPT_W-1:0] step_time;
  logic               plan_active;
  logic [IDX_W:0]     k;
  logic [T_W-1:0]     t;
  logic signed [63:0] p0, p1, v0, v1, a0, a1;
  logic signed [63:0] t2, vv0, vv1, aa, bb, q3, q4, q5, acc;
  logic signed [63:0] coef [0:5];
  logic [2:0]         hidx;
  logic [TAU_W-1:0]   tau;
  logic signed [63:0] h;
  logic signed [63:0] mul_a, mul_res, sum;
  logic [MB_W-1:0]    mul_b;
  logic               mul_done, div_done;
  logic [TAU_W-1:0]   div_q;
  logic               is_last;

  always_comb begin
    if (num_steps == '0) neff = IDX_W'(1);
    else if ({2'b0, num_steps} > 13'(MAX_STEPS)) neff = IDX_W'(MAX_STEPS);
    else neff = num_steps;
  end

  assign k       = {1'b0, sample_count} + 12'd1;
  assign is_last = (k == {1'b0, neff});
  assign h       = p1 - p0;

  always_comb begin
    mul_a = acc;
    mul_b = {{(MB_W-TAU_W){1'b0}}, tau};
    case (cmd.sel)
      M_T2: begin
        mul_a = {{(64-T_W){1'b0}}, t};
        mul_b = {{(MB_W-T_W){1'b0}}, t};
      end
      M_V0: begin
        mul_a = v0;
        mul_b = {{(MB_W-T_W){1'b0}}, t};
      end
      M_V1: begin
        mul_a = v1;
        mul_b = {{(MB_W-T_W){1'b0}}, t};
      end
      M_A: begin
        mul_a = a0;
        mul_b = t2[MB_W-1:0];
      end
      M_B: begin
        mul_a = a1;
        mul_b = t2[MB_W-1:0];
      end
      default: ;
    endcase
  end

  mjt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .go(cmd.op == DP_MUL), .tau_shift(cmd.sel == M_HORN),
    .a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
  );

  mjt_div u_div (
    .clk(clk), .rst(rst), .go(cmd.op == DP_DIV), .k(k), .n(neff),
    .done(div_done), .q(div_q)
  );

  assign sum = sat_add(mul_res, coef[hidx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps    <= NUM_STEPS_RST;
      step_time    <= STEP_TIME_RST;
      plan_active  <= 1'b0;
      sample_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_STEPS) num_steps <= cfg_data[IDX_W-1:0];
        else                            step_time <= cfg_data;
      end
      if (cmd.op == DP_OUT)           out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        DP_LOAD: begin
          if (in_data.op == OP_PLAN) begin
            p0 <= 64'(in_data.start_pos);
            v0 <= 64'(in_data.start_vel);
            a0 <= 64'(in_data.start_acc);
            p1 <= 64'(in_data.end_pos);
            v1 <= 64'(in_data.end_vel);
            a1 <= 64'(in_data.end_acc);
            t  <= neff * step_time;
          end else if (plan_active && (k > {1'b0, neff})) begin
            plan_active <= 1'b0;
          end
        end
        DP_MUL: begin
          if (mul_done) begin
            case (cmd.sel)
              M_T2: t2  <= mul_res;
              M_V0: vv0 <= mul_res;
              M_V1: vv1 <= mul_res;
              M_A:  aa  <= mul_res;
              M_B:  bb  <= mul_res;
              default: begin
                acc  <= sum;
                hidx <= hidx - 3'd1;
              end
            endcase
          end
        end
        DP_DIV: begin
          if (div_done) begin
            tau  <= div_q;
            acc  <= coef[5];
            hidx <= 3'd4;
          end
        end
        DP_Q: begin
          q3 <= half((aa <<< 1) + aa - bb);
          q4 <= half((aa <<< 1) + aa - (bb <<< 1));
          q5 <= half(bb - aa);
        end
        DP_C3: coef[3] <= (h <<< 3) + (h <<< 1) - (vv0 <<< 2) - (vv0 <<< 1)
                          - (vv1 <<< 2) - q3;
        DP_C4: coef[4] <= (vv0 <<< 3) + (vv1 <<< 3) - vv1 - (h <<< 4) + h + q4;
        DP_C5: begin
          coef[5]      <= (h <<< 2) + (h <<< 1) - (vv0 <<< 1) - vv0
                          - (vv1 <<< 1) - vv1 + q5;
          coef[0]      <= p0;
          coef[1]      <= vv0;
          coef[2]      <= half(aa);
          sample_count <= '0;
          plan_active  <= 1'b1;
        end
        DP_OUT: begin
          if (acc > 64'sd2147483647)       out_data.position <= 32'sh7fffffff;
          else if (acc < -64'sd2147483648) out_data.position <= 32'sh80000000;
          else                             out_data.position <= acc[31:0];
          out_data.sample_index <= k[IDX_W-1:0];
          out_data.last         <= is_last;
          sample_count          <= k[IDX_W-1:0];
          if (is_last) plan_active <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.in_op     = in_data.op;
    status.active    = plan_active;
    status.k_over    = (k > {1'b0, neff});
    status.mul_done  = mul_done;
    status.div_done  = div_done;
    status.hidx_zero = (hidx == 3'd0);
    status.out_free  = !out_valid || out_ready;
  end

  a_out_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_OUT) |=> out_valid)
    else $error("result not presented after output load");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_OUT) |=> (sample_count != '0))
    else $error("sample count zero after a sample");

  a_tau_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_q <= TAU_W'(1 << TAU_BITS)))
    else $error("normalized time above one");

  a_plan_armed: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_C5) |=> (plan_active && sample_count == '0))
    else $error("plan not armed after coefficients");

endmodule

// ===== src/mjt_ctrl.sv =====
// Controller state machine: sequences plan coefficient setup and sample
// evaluation through the datapath. Depends on mjt_pkg.
module mjt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mjt_pkg::status_t   status,
  output mjt_pkg::cmd_t      cmd
);
  import mjt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.op     = DP_NONE;
    cmd.sel    = M_HORN;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LOAD;
          if (status.in_op == OP_PLAN)            state_next = ST_T2;
          else if (status.active && !status.k_over) state_next = ST_DIV;
        end
      end
      ST_T2: begin
        cmd.op  = DP_MUL;
        cmd.sel = M_T2;
        if (status.mul_done) state_next = ST_V0;
      end
      ST_V0: begin
        cmd.op  = DP_MUL;
        cmd.sel = M_V0;
        if (status.mul_done) state_next = ST_V1;
      end
      ST_V1: begin
        cmd.op  = DP_MUL;
        cmd.sel = M_V1;
        if (status.mul_done) state_next = ST_A;
      end
      ST_A: begin
        cmd.op  = DP_MUL;
        cmd.sel = M_A;
        if (status.mul_done) state_next = ST_B;
      end
      ST_B: begin
        cmd.op  = DP_MUL;
        cmd.sel = M_B;
        if (status.mul_done) state_next = ST_Q;
      end
      ST_Q: begin
        cmd.op     = DP_Q;
        state_next = ST_C3;
      end
      ST_C3: begin
        cmd.op     = DP_C3;
        state_next = ST_C4;
      end
      ST_C4: begin
        cmd.op     = DP_C4;
        state_next = ST_C5;
      end
      ST_C5: begin
        cmd.op     = DP_C5;
        state_next = ST_IDLE;
      end
      ST_DIV: begin
        cmd.op = DP_DIV;
        if (status.div_done) state_next = ST_HORN;
      end
      ST_HORN: begin
        cmd.op  = DP_MUL;
        cmd.sel = M_HORN;
        if (status.mul_done && status.hidx_zero) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.op     = DP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/minimum_jerk_trajectory_unit.sv =====
// Minimum-jerk (quintic) trajectory unit, top level.
// Input channel (in_valid/in_ready/in_data): op OP_PLAN loads start/end
// position, velocity, acceleration and builds six coefficients, no result;
// op OP_STEP emits the next sample on the output channel
// (out_valid/out_ready/out_data) with its index and a last flag.
// Steps before a plan or past its last sample produce no beat.
// Config port: cfg_we/cfg_index/cfg_data writes num_steps or step_time;
// write only while idle.
// Timing: one item at a time. A plan beat is accepted, then five products
// run on the shared 64x16 multiplier and the Q, C3, C4 and C5 states combine them.
// A sample beat is accepted, then the divider forms tau (3 bits per cycle),
// five Horner products run, and the output register is loaded.
// A step that yields nothing is only accepted.
// The output register holds one result; input is accepted while it waits,
// and the next sample stalls in its output state until the receiver takes it.
// Reset (rst, synchronous) clears the plan, restores num_steps = 125 and
// step_time = 1311, and empties the output register.
// Depends on mjt_pkg, mjt_ctrl, mjt_datapath.
module minimum_jerk_trajectory_unit #(
  parameter int FRAC_BITS = mjt_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS = mjt_pkg::MAX_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mjt_pkg::mjt_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mjt_pkg::mjt_out_t             out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mjt_pkg::STEPT_W-1:0]   cfg_data
);
  import mjt_pkg::*;

  cmd_t    cmd;
  status_t status;

  mjt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .status(status), .cmd(cmd)
  );

  mjt_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_STEPS(MAX_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for minimum_jerk_trajectory_unit: predicts each sample from the
// plan/step items it drives and checks every output beat in order.
// Depends on mjt_pkg and the unit under test.
`timescale 1ns / 100ps
module tb;
  import mjt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mjt_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mjt_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_NUM_STEPS;
  logic [STEPT_W-1:0] cfg_data = '0;

  minimum_jerk_trajectory_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic signed [63:0] coef [6];
  int unsigned        steps_done;
  bit                 planning;
  logic [IDX_W-1:0]   n_reg;
  logic [STEPT_W-1:0] dt_reg;

  mjt_in_t  pending_items[$];
  mjt_out_t expected_samples[$];
  int       fails = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       hold_rx = 0;
  bit       in_ready_seen = 0;
  bit       out_taken = 0;
  event     hold_go;

  function automatic void queue_item(mjt_in_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // exact product, shift with truncation toward zero, saturate
  function automatic logic signed [63:0] mul_shift(logic signed [63:0] a,
                                                   logic signed [63:0] b, int sh);
    logic signed [127:0] p;
    logic [127:0] m;
    bit neg;
    p = 128'(a) * 128'(b);
    neg = p[127];
    m = neg ? -p : p;
    m = m >> sh;
    if (!neg && m > 128'h7FFF_FFFF_FFFF_FFFF) return S64_MAX;
    if (neg && m > 128'h8000_0000_0000_0000) return S64_MIN;
    return neg ? -m[63:0] : m[63:0];
  endfunction

  function automatic logic signed [63:0] halve(logic signed [63:0] x);
    return x / 2;
  endfunction

  function automatic int unsigned steps_eff();
    if (n_reg == 0) return 1;
    if (n_reg > 1024) return 1024;
    return n_reg;
  endfunction

  task automatic predict_item(mjt_in_t it);
    logic signed [63:0] p0, v0, a0, p1, v1, a1, t, t2, h, bv0, bv1, ba, bb, q3, q4, q5;
    logic signed [63:0] tau, acc;
    int unsigned n, k;
    mjt_out_t r;
    if (it.op == OP_PLAN) begin
      p0 = it.start_pos; v0 = it.start_vel; a0 = it.start_acc;
      p1 = it.end_pos;   v1 = it.end_vel;   a1 = it.end_acc;
      t = 64'(steps_eff()) * 64'(dt_reg);
      t2 = mul_shift(t, t, 16);
      h = p1 - p0;
      bv0 = mul_shift(v0, t, 16);
      bv1 = mul_shift(v1, t, 16);
      ba = mul_shift(a0, t2, 16);
      bb = mul_shift(a1, t2, 16);
      q3 = halve(sadd(mul_shift(ba, 3, 0), mul_shift(bb, -1, 0)));
      q4 = halve(sadd(mul_shift(ba, 3, 0), mul_shift(bb, -2, 0)));
      q5 = halve(sadd(bb, mul_shift(ba, -1, 0)));
      coef[0] = p0;
      coef[1] = bv0;
      coef[2] = halve(ba);
      coef[3] = sadd(sadd(sadd(mul_shift(h, 10, 0), mul_shift(bv0, -6, 0)),
                mul_shift(bv1, -4, 0)), mul_shift(q3, -1, 0));
      coef[4] = sadd(sadd(sadd(mul_shift(h, -15, 0), mul_shift(bv0, 8, 0)),
                mul_shift(bv1, 7, 0)), q4);
      coef[5] = sadd(sadd(sadd(mul_shift(h, 6, 0), mul_shift(bv0, -3, 0)),
                mul_shift(bv1, -3, 0)), q5);
      steps_done = 0;
      planning = 1;
    end else if (planning) begin
      n = steps_eff();
      k = steps_done + 1;
      if (k > n) planning = 0;
      else begin
        tau = 64'((64'(k) << TAU_BITS) / 64'(n));
        acc = coef[5];
        for (int i = 4; i >= 0; i--) acc = sadd(mul_shift(acc, tau, TAU_BITS), coef[i]);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        steps_done = k;
        r.position = acc[31:0];
        r.sample_index = k[IDX_W-1:0];
        r.last = (k == n);
        if (k == n) planning = 0;
        expected_samples.insert(expected_samples.size(), r);
      end
    end
  endtask

  // driver
  int tx_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_seen) begin
        tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 4) == 0) tx_gap = 0;
      end
      if (!in_valid || in_ready_seen) begin
        if (tx_gap == 0 && pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  // accept sampled at rising edge; the predictor runs on each accepted beat
  always @(posedge clk) begin
    in_ready_seen = 0;
    if (!rst && in_valid && in_ready) begin
      in_ready_seen = 1;
      predict_item(in_data);
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_go);
    hold_rx = 1;
    repeat (400) @(posedge clk);
    hold_rx = 0;
  end

  // receiver stall control
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rst || hold_rx) out_ready <= 1'b0;
    else begin
      if (out_taken) begin
        rx_gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) rx_gap = 0;
      end
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    mjt_out_t want;
    out_taken = 0;
    if (!rst && out_valid && out_ready) begin
      out_taken = 1;
      if (expected_samples.size() == 0) begin
        fails++;
        if (mismatches++ < 10) $display("unexpected beat: %h", out_data);
      end else begin
        want = expected_samples.pop_front();
        if (want !== out_data) begin
          fails++;
          if (mismatches++ < 10)
            $display("mismatch: exp pos %0d idx %0d last %0b, got pos %0d idx %0d last %0b",
                     want.position, want.sample_index, want.last,
                     out_data.position, out_data.sample_index, out_data.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || hold_rx || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic mjt_in_t mk_plan();
    mjt_in_t it;
    it.op = OP_PLAN;
    it.start_pos = rand_field(); it.start_vel = rand_field(); it.start_acc = rand_field();
    it.end_pos = rand_field();   it.end_vel = rand_field();   it.end_acc = rand_field();
    return it;
  endfunction

  function automatic mjt_in_t mk_step();
    mjt_in_t it;
    it = mk_plan();
    it.op = OP_STEP;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [STEPT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == CFG_NUM_STEPS) n_reg = val[IDX_W-1:0];
    else dt_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    mjt_in_t it;
    int unsigned n;
    n_reg = NUM_STEPS_RST;
    dt_reg = STEP_TIME_RST;
    planning = 0;
    steps_done = 0;
    for (int i = 0; i < 6; i++) coef[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: step with no plan, then a short plan at extremes
    queue_item(mk_step());
    drain();
    write_cfg(CFG_NUM_STEPS, 16'd4);
    it = mk_plan();
    it.start_pos = 32'h8000_0000; it.end_pos = 32'h7FFF_FFFF;
    it.start_vel = 32'h7FFF_FFFF; it.end_vel = 32'h8000_0000;
    it.start_acc = 32'h7FFF_FFFF; it.end_acc = 32'h8000_0000;
    queue_item(it);
    repeat (6) queue_item(mk_step());
    it = '0; it.op = OP_PLAN; it.end_pos = 32'h0001_0000;
    queue_item(it);
    queue_item(mk_step());
    queue_item(mk_plan());  // new plan mid-plan
    repeat (5) queue_item(mk_step());
    drain();
    write_cfg(CFG_STEP_TIME, 16'd0);
    write_cfg(CFG_NUM_STEPS, 16'd0);
    queue_item(mk_plan());
    repeat (2) queue_item(mk_step());
    drain();
    write_cfg(CFG_STEP_TIME, 16'hFFFF);
    write_cfg(CFG_NUM_STEPS, 16'd2047);   // clamps to the maximum
    queue_item(mk_plan());
    repeat (3) queue_item(mk_step());
    drain();
    // configuration change during a plan: shrink steps below count
    write_cfg(CFG_NUM_STEPS, 16'd2);
    repeat (3) queue_item(mk_step());
    drain();

    // long receiver hold-off: input backs up behind the full output register
    write_cfg(CFG_NUM_STEPS, 16'd8);
    queue_item(mk_plan());
    repeat (8) queue_item(mk_step());
    -> hold_go;
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: write_cfg(CFG_NUM_STEPS, 16'($urandom_range(1, 12)));
        1: write_cfg(CFG_NUM_STEPS, 16'($urandom_range(0, 40)));
        2: write_cfg(CFG_NUM_STEPS, 16'd1);
        3: write_cfg(CFG_NUM_STEPS, 16'($urandom_range(1000, 2047)));
        default: write_cfg(CFG_NUM_STEPS, 16'($urandom));
      endcase
      write_cfg(CFG_STEP_TIME, (ph == 4) ? 16'hFFFF : (ph == 7) ? 16'd1 : 16'($urandom));
      n = (n_reg == 0) ? 1 : (n_reg > 1024 ? 1024 : n_reg);
      for (int j = 0; j < 200; ) begin
        if ($urandom_range(0, 9) < 8) begin
          queue_item(mk_plan());
          for (int s = 0; s < ((n > 20) ? 12 : n + $urandom_range(0, 2)); s++)
            queue_item(mk_step());
          j += (n > 20) ? 13 : n + 1;
        end else begin
          queue_item($urandom_range(0, 1) ? mk_step() : mk_plan());
          j++;
        end
        while (pending_items.size() > 20) @(posedge clk);
      end
      drain();
    end
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== sim.f =====
src/mjt_pkg.sv
src/mjt_mul.sv
src/mjt_div.sv
src/mjt_datapath.sv
src/mjt_ctrl.sv
src/minimum_jerk_trajectory_unit.sv
test/tb.sv
